FILE: rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// shared widths, types and structs of the sjf / srtf schedule block
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int MAX_PROCS = 32;
  localparam int TIME_BITS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int SIM_W     = 22;
  localparam int TOT_W     = 27;
  localparam int PID_W     = 6;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [SIM_W-1:0]     sim_t;
  typedef logic [TOT_W-1:0]     tot_t;

  // running result of one scan pass over the stored processes
  typedef struct packed {
    logic  found;
    idx_t  pick;
    time_t best;
    logic  have_next;
    time_t next_arr;
  } scan_acc_t;

endpackage

FILE: rtl/sst_store.sv
// ----------------------------------------------------------------------------
// sst_store
// process record memories: one read address, registered read data
// ----------------------------------------------------------------------------
module sst_store (
  input  logic           clk,
  input  logic           ld_we,
  input  sst_pkg::idx_t  ld_addr,
  input  sst_pkg::time_t ld_arr,
  input  sst_pkg::time_t ld_bst,
  input  logic           rem_we,
  input  logic           ct_we,
  input  sst_pkg::idx_t  upd_addr,
  input  sst_pkg::time_t rem_wdata,
  input  sst_pkg::sim_t  ct_wdata,
  input  sst_pkg::idx_t  rd_addr,
  output sst_pkg::time_t rd_arr,
  output sst_pkg::time_t rd_bst,
  output sst_pkg::time_t rd_rem,
  output sst_pkg::sim_t  rd_ct
);

  sst_pkg::time_t arr_mem [sst_pkg::MAX_PROCS];
  sst_pkg::time_t bst_mem [sst_pkg::MAX_PROCS];
  sst_pkg::time_t rem_mem [sst_pkg::MAX_PROCS];
  sst_pkg::sim_t  ct_mem  [sst_pkg::MAX_PROCS];

  always_ff @(posedge clk) begin
    if (ld_we) begin
      arr_mem[ld_addr] <= ld_arr;
      bst_mem[ld_addr] <= ld_bst;
    end
    // loads and schedule updates never overlap
    if (ld_we) begin
      rem_mem[ld_addr] <= ld_bst;
    end else if (rem_we) begin
      rem_mem[upd_addr] <= rem_wdata;
    end
    if (ct_we) begin
      ct_mem[upd_addr] <= ct_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_arr <= arr_mem[rd_addr];
    rd_bst <= bst_mem[rd_addr];
    rd_rem <= rem_mem[rd_addr];
    rd_ct  <= ct_mem[rd_addr];
  end

endmodule

FILE: rtl/sst_scan_unit.sv
// ----------------------------------------------------------------------------
// sst_scan_unit
// shared compare unit: folds one process record per cycle, while vld is high, into the pick
// ----------------------------------------------------------------------------
module sst_scan_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  logic               vld,
  input  sst_pkg::idx_t      idx,
  input  logic               done,
  input  sst_pkg::time_t     arrival,
  input  sst_pkg::time_t     burst,
  input  sst_pkg::time_t     remaining,
  input  sst_pkg::sim_t      sim_time,
  input  logic               mode,
  output sst_pkg::scan_acc_t acc
);

  sst_pkg::scan_acc_t acc_r;
  sst_pkg::time_t     key;
  logic               not_arrived;

  assign key         = mode ? remaining : burst;
  assign not_arrived = sst_pkg::sim_t'(arrival) > sim_time;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r.found     <= 1'b0;
      acc_r.have_next <= 1'b0;
    end else if (clr) begin
      acc_r.found     <= 1'b0;
      acc_r.have_next <= 1'b0;
    end else if (vld && !done) begin
      if (not_arrived) begin
        if (!acc_r.have_next || (arrival < acc_r.next_arr)) begin
          acc_r.next_arr  <= arrival;
          acc_r.have_next <= 1'b1;
        end
      end else if (!acc_r.found || (key < acc_r.best)) begin
        // strict less-than keeps the lowest index on ties
        acc_r.best  <= key;
        acc_r.pick  <= idx;
        acc_r.found <= 1'b1;
      end
    end
  end

  assign acc = acc_r;

endmodule

FILE: rtl/sst_emit.sv
// ----------------------------------------------------------------------------
// sst_emit
// result pipeline: turnaround and waiting times, then running totals
// ----------------------------------------------------------------------------
module sst_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic                        in_vld,
  input  sst_pkg::idx_t               in_idx,
  input  logic                        in_last,
  input  sst_pkg::time_t              arrival,
  input  sst_pkg::time_t              burst,
  input  sst_pkg::sim_t               completion,
  output logic                        out_valid,
  output logic [sst_pkg::PID_W-1:0]   out_process_id,
  output sst_pkg::sim_t               out_completion_time,
  output sst_pkg::sim_t               out_turnaround_time,
  output sst_pkg::sim_t               out_waiting_time,
  output sst_pkg::tot_t               out_total_turnaround,
  output sst_pkg::tot_t               out_total_waiting,
  output logic                        out_last_result
);

  logic                      a_vld_r;
  logic [sst_pkg::PID_W-1:0] a_pid_r;
  logic                      a_last_r;
  sst_pkg::sim_t             a_ct_r;
  sst_pkg::sim_t             a_tat_r;
  sst_pkg::sim_t             a_wt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_pid_r  <= sst_pkg::PID_W'(sst_pkg::cnt_t'(in_idx) + sst_pkg::cnt_t'(1));
    a_last_r <= in_last;
    a_ct_r   <= completion;
    a_tat_r  <= completion - sst_pkg::sim_t'(arrival);
    a_wt_r   <= completion - sst_pkg::sim_t'(arrival) - sst_pkg::sim_t'(burst);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      out_total_turnaround <= '0;
      out_total_waiting    <= '0;
    end else if (a_vld_r) begin
      out_total_turnaround <= out_total_turnaround + sst_pkg::tot_t'(a_tat_r);
      out_total_waiting    <= out_total_waiting + sst_pkg::tot_t'(a_wt_r);
    end
    if (a_vld_r) begin
      out_process_id      <= a_pid_r;
      out_completion_time <= a_ct_r;
      out_turnaround_time <= a_tat_r;
      out_waiting_time    <= a_wt_r;
      out_last_result     <= a_last_r;
    end
  end

endmodule

FILE: rtl/sjf_srtf_schedule_times.sv
// ----------------------------------------------------------------------------
// sjf_srtf_schedule_times
// sjf / srtf cpu schedule calculator: loads process records, simulates one
// cpu and reports completion, turnaround and waiting times per process
// ----------------------------------------------------------------------------
// schedule: after the closing record the schedule runs in passes, each of n
//   scan reads through the one memory read port, one read tail and one
//   resolve step; results then come out on consecutive cycles
// throughput: one record per cycle while loading; busy from the closing
//   record until the final result strobe; the receiver cannot stall
// reset: synchronous active-low rst_n clears control state and the mode
// ----------------------------------------------------------------------------
module sjf_srtf_schedule_times (
  input  logic                          clk,
  input  logic                          rst_n,
  // record input
  input  logic                          start,
  output logic                          busy,
  input  logic [sst_pkg::TIME_BITS-1:0] in_arrival_time,
  input  logic [sst_pkg::TIME_BITS-1:0] in_burst_time,
  input  logic                          in_last_process,
  // result output
  output logic                          out_valid,
  output logic [sst_pkg::PID_W-1:0]     out_process_id,
  output logic [sst_pkg::SIM_W-1:0]     out_completion_time,
  output logic [sst_pkg::SIM_W-1:0]     out_turnaround_time,
  output logic [sst_pkg::SIM_W-1:0]     out_waiting_time,
  output logic [sst_pkg::TOT_W-1:0]     out_total_turnaround,
  output logic [sst_pkg::TOT_W-1:0]     out_total_waiting,
  output logic                          out_last_result,
  // mode register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_preemptive_mode
);

  // sequencer states
  localparam logic [1:0] ST_LOAD    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_RESOLVE = 2'd2;
  localparam logic [1:0] ST_EMIT    = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic                   mode_r;
  sst_pkg::cnt_t          loaded_r, loaded_nxt;
  sst_pkg::cnt_t          finished_r, finished_nxt;
  sst_pkg::sim_t          time_r, time_nxt;
  sst_pkg::cnt_t          rd_idx_r, rd_idx_nxt;
  logic [sst_pkg::MAX_PROCS-1:0] done_r, done_nxt;
  logic                   vld_r;
  sst_pkg::idx_t          vidx_r;

  logic                   accept;
  logic                   ld_we;
  sst_pkg::time_t         ld_bst;
  logic                   issue;
  sst_pkg::idx_t          rd_addr;
  sst_pkg::cnt_t          last_cnt;
  logic                   vld_is_last;
  logic                   scan_clr;
  logic                   emit_clr;

  sst_pkg::time_t         rd_arr, rd_bst, rd_rem;
  sst_pkg::sim_t          rd_ct;
  sst_pkg::scan_acc_t     acc;

  // resolve step datapath
  sst_pkg::sim_t          gap;
  logic                   cut;
  sst_pkg::sim_t          span;
  sst_pkg::sim_t          time_run;
  sst_pkg::time_t         rem_new;
  logic                   rem_we;
  logic                   ct_we;

  assign busy      = (state_r != ST_LOAD);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // records past a full store are dropped, a zero burst counts as one unit
  assign ld_we  = accept && (loaded_r != sst_pkg::cnt_t'(sst_pkg::MAX_PROCS));
  assign ld_bst = (in_burst_time == '0) ? sst_pkg::time_t'(1) : in_burst_time;

  // one read port shared by the scan passes and the result readout
  assign issue   = ((state_r == ST_SCAN) || (state_r == ST_EMIT)) && (rd_idx_r != loaded_r);
  assign rd_addr = rd_idx_r[sst_pkg::IDX_W-1:0];

  assign last_cnt    = loaded_r - sst_pkg::cnt_t'(1);
  assign vld_is_last = vld_r && (vidx_r == last_cnt[sst_pkg::IDX_W-1:0]);

  // run the picked process until done, or in srtf until the next arrival
  assign gap      = sst_pkg::sim_t'(acc.next_arr) - time_r;
  assign cut      = mode_r && acc.have_next && (gap < sst_pkg::sim_t'(acc.best));
  assign span     = cut ? gap : sst_pkg::sim_t'(acc.best);
  assign time_run = time_r + span;
  assign rem_new  = acc.best - span[sst_pkg::TIME_BITS-1:0];
  assign rem_we   = (state_r == ST_RESOLVE) && acc.found;
  assign ct_we    = rem_we && (rem_new == '0);

  always_comb begin
    state_nxt    = state_r;
    loaded_nxt   = loaded_r;
    finished_nxt = finished_r;
    time_nxt     = time_r;
    rd_idx_nxt   = issue ? rd_idx_r + sst_pkg::cnt_t'(1) : rd_idx_r;
    done_nxt     = done_r;
    scan_clr     = 1'b0;
    emit_clr     = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (ld_we) begin
          loaded_nxt = loaded_r + sst_pkg::cnt_t'(1);
        end
        if (accept && in_last_process) begin
          state_nxt    = ST_SCAN;
          time_nxt     = '0;
          finished_nxt = '0;
          rd_idx_nxt   = '0;
          scan_clr     = 1'b1;
        end
      end
      ST_SCAN: begin
        if (vld_is_last) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        rd_idx_nxt = '0;
        if (acc.found) begin
          time_nxt = time_run;
          if (ct_we) begin
            done_nxt[acc.pick] = 1'b1;
            finished_nxt       = finished_r + sst_pkg::cnt_t'(1);
          end
        end else begin
          // nothing has arrived: skip ahead to the next arrival
          time_nxt = acc.have_next ? sst_pkg::sim_t'(acc.next_arr)
                                   : time_r + sst_pkg::sim_t'(1);
        end
        if (finished_nxt == loaded_r) begin
          state_nxt = ST_EMIT;
          emit_clr  = 1'b1;
        end else begin
          state_nxt = ST_SCAN;
          scan_clr  = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_valid && out_last_result) begin
          // set delivered: ready for the next set of records
          state_nxt    = ST_LOAD;
          loaded_nxt   = '0;
          finished_nxt = '0;
          time_nxt     = '0;
          done_nxt     = '0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      mode_r     <= 1'b0;
      loaded_r   <= '0;
      finished_r <= '0;
      time_r     <= '0;
      rd_idx_r   <= '0;
      done_r     <= '0;
      vld_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      loaded_r   <= loaded_nxt;
      finished_r <= finished_nxt;
      time_r     <= time_nxt;
      rd_idx_r   <= rd_idx_nxt;
      done_r     <= done_nxt;
      vld_r      <= issue;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_preemptive_mode;
      end
    end
  end

  // index of the record whose read data shows up next cycle
  always_ff @(posedge clk) begin
    vidx_r <= rd_addr;
  end

  sst_store u_store (
    .clk       (clk),
    .ld_we     (ld_we),
    .ld_addr   (loaded_r[sst_pkg::IDX_W-1:0]),
    .ld_arr    (in_arrival_time),
    .ld_bst    (ld_bst),
    .rem_we    (rem_we),
    .ct_we     (ct_we),
    .upd_addr  (acc.pick),
    .rem_wdata (rem_new),
    .ct_wdata  (time_run),
    .rd_addr   (rd_addr),
    .rd_arr    (rd_arr),
    .rd_bst    (rd_bst),
    .rd_rem    (rd_rem),
    .rd_ct     (rd_ct)
  );

  sst_scan_unit u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (scan_clr),
    .vld       (vld_r && (state_r == ST_SCAN)),
    .idx       (vidx_r),
    .done      (done_r[vidx_r]),
    .arrival   (rd_arr),
    .burst     (rd_bst),
    .remaining (rd_rem),
    .sim_time  (time_r),
    .mode      (mode_r),
    .acc       (acc)
  );

  sst_emit u_emit (
    .clk                  (clk),
    .rst_n                (rst_n),
    .clr                  (emit_clr),
    .in_vld               (vld_r && (state_r == ST_EMIT)),
    .in_idx               (vidx_r),
    .in_last              (vld_is_last),
    .arrival              (rd_arr),
    .burst                (rd_bst),
    .completion           (rd_ct),
    .out_valid            (out_valid),
    .out_process_id       (out_process_id),
    .out_completion_time  (out_completion_time),
    .out_turnaround_time  (out_turnaround_time),
    .out_waiting_time     (out_waiting_time),
    .out_total_turnaround (out_total_turnaround),
    .out_total_waiting    (out_total_waiting),
    .out_last_result      (out_last_result)
  );

endmodule
